// File: rtl/core/hdsd_pkg.sv
package hdsd_pkg;

  // window geometry and derived widths
  localparam int unsigned WINDOW_DEPTH = 6;
  localparam int unsigned SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TOT_W   = 32 + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0);
  localparam int unsigned MILLI_SCALE = 1000;
  localparam int unsigned PHASES  = 6;
  localparam int unsigned SCALE_W = $clog2(MILLI_SCALE * WINDOW_DEPTH + 1);
  localparam int unsigned NUM_W   = 32 + SCALE_W;
  localparam int unsigned DEN_W   = TOT_W + 3;
  localparam int unsigned CNT_W   = $clog2(NUM_W);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_SEQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLK_HZ  = 1'd1;

  localparam logic [17:0] FWD_SEQ_RST = 18'd137907;
  localparam logic [31:0] CLK_HZ_RST  = 32'd100000000;

  // item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_EDGE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FREQ,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic mul;
    logic div_step;
    logic freq_wr;
    logic out_ld;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/hdsd_datapath.sv
module hdsd_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hdsd_pkg::cmd_t     cmd,
  output hdsd_pkg::sts_t     sts,
  input  logic               cfg_we,
  input  logic [hdsd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_op,
  input  logic [2:0]         in_hall_state,
  input  logic [31:0]        in_ext_count,
  input  logic [31:0]        in_edge_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [2:0]         out_current_hall,
  output logic               out_hall_valid,
  output logic signed [1:0]  out_rotation,
  output logic [31:0]        out_last_good_time,
  output logic [31:0]        out_last_ext_count,
  output logic [31:0]        out_frequency_millihz,
  output logic [31:0]        out_frequency_updates,
  output logic [31:0]        out_forward_steps,
  output logic [31:0]        out_reverse_steps,
  output logic [31:0]        out_duplicate_edges,
  output logic [31:0]        out_invalid_edges
);
  import hdsd_pkg::*;

  // successor of a hall state in a packed forward table
  function automatic logic [2:0] succ_of(input logic [17:0] tbl, input logic [2:0] s);
    logic [2:0] n;
    n = 3'd0;
    case (s)
      3'd1: n = tbl[2:0];
      3'd2: n = tbl[5:3];
      3'd3: n = tbl[8:6];
      3'd4: n = tbl[11:9];
      3'd5: n = tbl[14:12];
      3'd6: n = tbl[17:15];
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // table must be one closed 1..6 cycle of single-bit steps
  function automatic logic tbl_ok(input logic [17:0] tbl);
    logic       ok;
    logic [7:0] seen;
    logic [2:0] s;
    logic [2:0] n;
    logic [2:0] d;
    ok = 1'b1;
    seen = 8'd0;
    for (int k = 1; k <= 6; k++) begin
      n = succ_of(tbl, 3'(k));
      d = 3'(k) ^ n;
      if (n == 3'd0 || n == 3'd7) ok = 1'b0;
      if (d != 3'd1 && d != 3'd2 && d != 3'd4) ok = 1'b0;
    end
    s = 3'd1;
    for (int k = 0; k < 6; k++) begin
      if (seen[s]) ok = 1'b0;
      seen[s] = 1'b1;
      s = succ_of(tbl, s);
    end
    if (s != 3'd1) ok = 1'b0;
    return ok;
  endfunction

  // config and latched copies
  logic [17:0] cfg_fwd_r, fwd_l_r, fwd_l_nxt;
  logic [31:0] cfg_clk_r, clk_l_r, clk_l_nxt;

  // decoder state
  logic              armed_r, armed_nxt;
  logic [2:0]        hall_r, hall_nxt;
  logic signed [1:0] dir_r, dir_nxt;
  logic signed [1:0] wdir_r, wdir_nxt;
  logic [31:0]       good_r, good_nxt;
  logic [31:0]       wstart_r, wstart_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [31:0]       ecs_r, ecs_nxt;
  logic [31:0]       freq_r, freq_nxt;
  logic [31:0]       upd_r, upd_nxt;
  logic [31:0]       fwd_cnt_r, fwd_cnt_nxt;
  logic [31:0]       rev_cnt_r, rev_cnt_nxt;
  logic [31:0]       dup_cnt_r, dup_cnt_nxt;
  logic [31:0]       inv_cnt_r, inv_cnt_nxt;
  logic              acc_r, acc_nxt;
  logic              need_div;
  logic              win_we;
  logic [31:0]       win_r [WINDOW_DEPTH];

  // divider
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic [SCALE_W-1:0] scale;

  logic [31:0] iv;
  logic [2:0]  prev;
  logic        nv, pv;

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fwd_r <= FWD_SEQ_RST;
      cfg_clk_r <= CLK_HZ_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FWD_SEQ: cfg_fwd_r <= cfg_wdata[17:0];
        REG_CLK_HZ:  cfg_clk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item evaluation
  always_comb begin
    fwd_l_nxt = fwd_l_r;   clk_l_nxt = clk_l_r;
    armed_nxt = armed_r;   hall_nxt = hall_r;
    dir_nxt = dir_r;       wdir_nxt = wdir_r;
    good_nxt = good_r;     wstart_nxt = wstart_r;
    slot_nxt = slot_r;     fill_nxt = fill_r;
    total_nxt = total_r;   ecs_nxt = ecs_r;
    freq_nxt = freq_r;     upd_nxt = upd_r;
    fwd_cnt_nxt = fwd_cnt_r; rev_cnt_nxt = rev_cnt_r;
    dup_cnt_nxt = dup_cnt_r; inv_cnt_nxt = inv_cnt_r;
    acc_nxt = acc_r;
    need_div = 1'b0;
    win_we = 1'b0;
    prev = hall_r;
    nv = (in_hall_state != 3'd0) && (in_hall_state != 3'd7);
    pv = (prev != 3'd0) && (prev != 3'd7);
    iv = in_edge_time - wstart_r;

    if (cmd.exec) begin
      acc_nxt = 1'b0;
      if (in_op == OP_START) begin
        armed_nxt = 1'b0;  hall_nxt = 3'd0;
        dir_nxt = 2'sd0;   wdir_nxt = 2'sd0;
        good_nxt = 32'd0;  ecs_nxt = 32'd0;
        freq_nxt = 32'd0;  upd_nxt = 32'd0;
        fwd_cnt_nxt = 32'd0; rev_cnt_nxt = 32'd0;
        dup_cnt_nxt = 32'd0; inv_cnt_nxt = 32'd0;
        total_nxt = '0; wstart_nxt = 32'd0; slot_nxt = '0; fill_nxt = '0;
        if (tbl_ok(cfg_fwd_r) && cfg_clk_r != 32'd0) begin
          fwd_l_nxt = cfg_fwd_r;
          clk_l_nxt = cfg_clk_r;
          hall_nxt = in_hall_state;
          good_nxt = in_edge_time;
          wstart_nxt = in_edge_time;
          armed_nxt = 1'b1;
          acc_nxt = 1'b1;
        end
      end else if (armed_r) begin
        hall_nxt = in_hall_state;
        ecs_nxt = in_ext_count;
        if (in_hall_state == prev) begin
          dup_cnt_nxt = dup_cnt_r + 32'd1;
        end else if (!nv || !pv ||
                     (succ_of(fwd_l_r, prev) != in_hall_state &&
                      succ_of(fwd_l_r, in_hall_state) != prev)) begin
          // invalid state or illegal step
          inv_cnt_nxt = inv_cnt_r + 32'd1;
          dir_nxt = 2'sd0; wdir_nxt = 2'sd0; freq_nxt = 32'd0;
          total_nxt = '0; wstart_nxt = in_edge_time; slot_nxt = '0; fill_nxt = '0;
        end else begin
          if (succ_of(fwd_l_r, prev) == in_hall_state) begin
            fwd_cnt_nxt = fwd_cnt_r + 32'd1;
            dir_nxt = 2'sd1;
          end else begin
            rev_cnt_nxt = rev_cnt_r + 32'd1;
            dir_nxt = -2'sd1;
          end
          good_nxt = in_edge_time;
          acc_nxt = 1'b1;
          if (dir_nxt != wdir_r) begin
            // direction change restarts the window
            wdir_nxt = dir_nxt; freq_nxt = 32'd0;
            total_nxt = '0; wstart_nxt = in_edge_time; slot_nxt = '0; fill_nxt = '0;
          end else begin
            wstart_nxt = in_edge_time;
            if (iv != 32'd0) begin
              win_we = 1'b1;
              need_div = 1'b1;
              if (fill_r >= FILL_W'(WINDOW_DEPTH)) begin
                total_nxt = total_r - TOT_W'(win_r[slot_r]) + TOT_W'(iv);
              end else begin
                fill_nxt = fill_r + FILL_W'(1);
                total_nxt = total_r + TOT_W'(iv);
              end
              slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
              upd_nxt = upd_r + 32'd1;
            end
          end
        end
      end
    end

    if (cmd.freq_wr) begin
      freq_nxt = (quot_r[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : quot_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_l_r <= '0;   clk_l_r <= '0;
      armed_r <= 1'b0; hall_r <= '0;
      dir_r <= '0;     wdir_r <= '0;
      good_r <= '0;    wstart_r <= '0;
      slot_r <= '0;    fill_r <= '0;
      total_r <= '0;   ecs_r <= '0;
      freq_r <= '0;    upd_r <= '0;
      fwd_cnt_r <= '0; rev_cnt_r <= '0;
      dup_cnt_r <= '0; inv_cnt_r <= '0;
      acc_r <= 1'b0;
    end else begin
      fwd_l_r <= fwd_l_nxt;   clk_l_r <= clk_l_nxt;
      armed_r <= armed_nxt;   hall_r <= hall_nxt;
      dir_r <= dir_nxt;       wdir_r <= wdir_nxt;
      good_r <= good_nxt;     wstart_r <= wstart_nxt;
      slot_r <= slot_nxt;     fill_r <= fill_nxt;
      total_r <= total_nxt;   ecs_r <= ecs_nxt;
      freq_r <= freq_nxt;     upd_r <= upd_nxt;
      fwd_cnt_r <= fwd_cnt_nxt; rev_cnt_r <= rev_cnt_nxt;
      dup_cnt_r <= dup_cnt_nxt; inv_cnt_r <= inv_cnt_nxt;
      acc_r <= acc_nxt;
    end
  end

  // interval window; entries past fill are never read
  always_ff @(posedge clk) begin
    if (win_we) win_r[slot_r] <= iv;
  end

  // numerator and divisor setup, then restoring divide one bit a cycle
  assign scale  = SCALE_W'(fill_r) * SCALE_W'(MILLI_SCALE);
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num_r  <= NUM_W'(clk_l_r) * NUM_W'(scale);
      den_r  <= DEN_W'(total_r) * DEN_W'(PHASES);
      rem_r  <= '0;
      quot_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      rem_r  <= q_bit ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      quot_r <= {quot_r[NUM_W-2:0], q_bit};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_accepted          <= acc_r;
      out_current_hall      <= hall_r;
      out_hall_valid        <= (hall_r != 3'd0) && (hall_r != 3'd7);
      out_rotation          <= dir_r;
      out_last_good_time    <= good_r;
      out_last_ext_count    <= ecs_r;
      out_frequency_millihz <= freq_r;
      out_frequency_updates <= upd_r;
      out_forward_steps     <= fwd_cnt_r;
      out_reverse_steps     <= rev_cnt_r;
      out_duplicate_edges   <= dup_cnt_r;
      out_invalid_edges     <= inv_cnt_r;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_last = (cnt_r == CNT_W'(NUM_W - 1));
  assign sts.out_free = !out_valid || !out_stall;

  // window bookkeeping stays consistent
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH)) else $error("window fill overflow");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> total_r == '0) else $error("empty window with nonzero total");
  a_disarmed_dir: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (dir_r == 2'sd0 && wdir_r == 2'sd0)) else $error("direction while disarmed");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> den_r != '0) else $error("divide by zero total");

endmodule

// File: rtl/core/hdsd_ctrl.sv
module hdsd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hdsd_pkg::sts_t sts,
  output hdsd_pkg::cmd_t cmd
);
  import hdsd_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = sts.need_div ? ST_MUL : ST_OUT;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_last) state_nxt = ST_FREQ;
      ST_FREQ: state_nxt = ST_OUT;
      ST_OUT:  if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // commands
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.exec = in_valid;
      end
      ST_MUL:  cmd.mul = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FREQ: cmd.freq_wr = 1'b1;
      ST_OUT:  cmd.out_ld = sts.out_free;
      default: ;
    endcase
  end

  a_exec_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !in_stall) else $error("item taken while busy");
  a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> cmd.div_step) else $error("divide did not follow setup");
  a_freq_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.freq_wr |-> $past(cmd.div_step)) else $error("frequency written without divide");

endmodule

// File: rtl/core/hall_direction_speed_decoder_unit.sv
// channel  | direction | handshake            | payload
// cfg      | in        | cfg_we               | cfg_idx, cfg_wdata
// in       | in        | in_valid / in_stall  | op, hall_state, ext_count, edge_time
// out      | out       | out_valid / out_stall| accepted .. invalid_edges
// A start, a duplicate, an invalid, a zero-interval or a window-restarting edge goes
// straight to output load. A step that adds a window sample runs one setup multiply,
// then a restoring divide, one bit per cycle, plus frequency write and output load.
// Reset (rst_n low, synchronous) clears all counters, disarms the block and
// restores the forward table and clock registers to their defaults.
// A stalled result holds; a new word is taken while the previous one waits.
module hall_direction_speed_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [hdsd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [2:0]         in_hall_state,
  input  logic [31:0]        in_ext_count,
  input  logic [31:0]        in_edge_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [2:0]         out_current_hall,
  output logic               out_hall_valid,
  output logic signed [1:0]  out_rotation,
  output logic [31:0]        out_last_good_time,
  output logic [31:0]        out_last_ext_count,
  output logic [31:0]        out_frequency_millihz,
  output logic [31:0]        out_frequency_updates,
  output logic [31:0]        out_forward_steps,
  output logic [31:0]        out_reverse_steps,
  output logic [31:0]        out_duplicate_edges,
  output logic [31:0]        out_invalid_edges
);
  import hdsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hdsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdsd_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_idx               (cfg_idx),
    .cfg_wdata             (cfg_wdata),
    .in_op                 (in_op),
    .in_hall_state         (in_hall_state),
    .in_ext_count          (in_ext_count),
    .in_edge_time          (in_edge_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_current_hall      (out_current_hall),
    .out_hall_valid        (out_hall_valid),
    .out_rotation          (out_rotation),
    .out_last_good_time    (out_last_good_time),
    .out_last_ext_count    (out_last_ext_count),
    .out_frequency_millihz (out_frequency_millihz),
    .out_frequency_updates (out_frequency_updates),
    .out_forward_steps     (out_forward_steps),
    .out_reverse_steps     (out_reverse_steps),
    .out_duplicate_edges   (out_duplicate_edges),
    .out_invalid_edges     (out_invalid_edges)
  );

endmodule
